### design/hid_keyboard_report_decoder_unit_assert.svh
// Assertion macros for the keyboard report decoder
`ifndef HID_KEYBOARD_REPORT_DECODER_UNIT_ASSERT_SVH
`define HID_KEYBOARD_REPORT_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HKRD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hkrd assertion failed");
`define HKRD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hkrd assertion failed");
`else
`define HKRD_ASSERT_NOW(lbl, pre, post)
`define HKRD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### design/hkrd_pkg.sv
// Types, key codes and decode functions for the keyboard report decoder
package hkrd_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int SLOT_IDX_W  = 3;
  localparam int REPORT_BYTES = 9;
  localparam int LEN_W       = 7;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 16;

  localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;

  localparam logic [7:0] KEY_CAPS      = 8'h39;
  localparam logic [7:0] KEY_ESCAPE    = 8'h29;
  localparam logic [7:0] KEY_L         = 8'h0F;
  localparam logic [7:0] KEY_UP        = 8'h52;
  localparam logic [7:0] KEY_DOWN      = 8'h51;
  localparam logic [7:0] KEY_LEFT      = 8'h50;
  localparam logic [7:0] KEY_RIGHT     = 8'h4F;
  localparam logic [7:0] KEY_ENTER     = 8'h28;
  localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
  localparam logic [7:0] KEY_A         = 8'h04;
  localparam logic [7:0] KEY_Z         = 8'h1D;
  localparam logic [7:0] KEY_1         = 8'h1E;
  localparam logic [7:0] KEY_0         = 8'h27;
  localparam logic [7:0] KEY_SPACE     = 8'h2C;
  localparam logic [7:0] KEY_SLASH     = 8'h38;
  localparam logic [7:0] KEY_NON_US    = 8'h32;

  typedef enum logic [3:0] {
    EV_ESCAPE,
    EV_URL_FOCUS,
    EV_SCROLL_UP,
    EV_SCROLL_DOWN,
    EV_LEFT,
    EV_RIGHT,
    EV_ENTER,
    EV_BACKSPACE,
    EV_CHAR,
    EV_LEDS
  } event_kind_t;

  typedef struct packed {
    logic [KEY_SLOTS-1:0][7:0] keys;
    logic                      ctrl;
    logic                      shift;
    logic [KEY_SLOTS-1:0]      emit;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    event_kind_t kind;
    logic [6:0]  ch;
  } key_event_t;

  function automatic logic code_emits(input logic [7:0] code);
    logic e;
    e = (code == KEY_CAPS) || (code == KEY_ESCAPE) || (code == KEY_UP) ||
        (code == KEY_DOWN) || (code == KEY_LEFT) || (code == KEY_RIGHT) ||
        (code == KEY_ENTER) || (code == KEY_BACKSPACE) ||
        ((code >= KEY_A) && (code <= KEY_Z)) ||
        ((code >= KEY_1) && (code <= KEY_0)) ||
        ((code >= KEY_SPACE) && (code <= KEY_SLASH) && (code != KEY_NON_US));
    return e;
  endfunction

  function automatic logic [6:0] digit_char(input logic [7:0] code, input logic shift);
    logic [6:0] c;
    unique case (code)
      8'h1E:   c = shift ? 7'h21 : 7'h31;
      8'h1F:   c = shift ? 7'h40 : 7'h32;
      8'h20:   c = shift ? 7'h23 : 7'h33;
      8'h21:   c = shift ? 7'h24 : 7'h34;
      8'h22:   c = shift ? 7'h25 : 7'h35;
      8'h23:   c = shift ? 7'h5E : 7'h36;
      8'h24:   c = shift ? 7'h26 : 7'h37;
      8'h25:   c = shift ? 7'h2A : 7'h38;
      8'h26:   c = shift ? 7'h28 : 7'h39;
      8'h27:   c = shift ? 7'h29 : 7'h30;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] symbol_char(input logic [7:0] code, input logic shift);
    logic [6:0] c;
    unique case (code)
      8'h2C:   c = 7'h20;
      8'h2D:   c = shift ? 7'h5F : 7'h2D;
      8'h2E:   c = shift ? 7'h2B : 7'h3D;
      8'h2F:   c = shift ? 7'h7B : 7'h5B;
      8'h30:   c = shift ? 7'h7D : 7'h5D;
      8'h31:   c = shift ? 7'h7C : 7'h5C;
      8'h33:   c = shift ? 7'h3A : 7'h3B;
      8'h34:   c = shift ? 7'h22 : 7'h27;
      8'h35:   c = shift ? 7'h7E : 7'h60;
      8'h36:   c = shift ? 7'h3C : 7'h2C;
      8'h37:   c = shift ? 7'h3E : 7'h2E;
      8'h38:   c = shift ? 7'h3F : 7'h2F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic key_event_t decode_key(input logic [7:0] code, input logic ctrl,
                                            input logic shift, input logic caps);
    key_event_t ev;
    logic [6:0] letter;
    letter = 7'h61 + (code[6:0] - KEY_A[6:0]);
    ev.ch  = 7'h00;
    priority if (code == KEY_CAPS)          ev.kind = EV_LEDS;
    else if (code == KEY_ESCAPE)            ev.kind = EV_ESCAPE;
    else if (ctrl && (code == KEY_L))       ev.kind = EV_URL_FOCUS;
    else if (code == KEY_UP)                ev.kind = EV_SCROLL_UP;
    else if (code == KEY_DOWN)              ev.kind = EV_SCROLL_DOWN;
    else if (code == KEY_LEFT)              ev.kind = EV_LEFT;
    else if (code == KEY_RIGHT)             ev.kind = EV_RIGHT;
    else if (code == KEY_ENTER)             ev.kind = EV_ENTER;
    else if (code == KEY_BACKSPACE)         ev.kind = EV_BACKSPACE;
    else begin
      ev.kind = EV_CHAR;
      priority if ((code >= KEY_A) && (code <= KEY_Z))
        ev.ch = (shift != caps) ? (letter - 7'd32) : letter;
      else if ((code >= KEY_1) && (code <= KEY_0))
        ev.ch = digit_char(code, shift);
      else
        ev.ch = symbol_char(code, shift);
    end
    return ev;
  endfunction

endpackage

### design/hid_keyboard_report_decoder_unit.sv
// Top level of the USB HID boot keyboard report decoder
// Takes one keyboard report per transaction and emits zero to six key events,
// one result transaction per cycle when the sink is ready. The intake stage
// accepts a report every cycle while its two-entry job queue has room; a report
// that yields N events holds the event generator until all are out, so sustained
// throughput is set by the event generator at one event per clock while the
// sink is ready. Reports that are short, empty, repeated or hold only unmapped
// codes produce nothing. Caps Lock and the remembered key set clear on reset.
`include "hid_keyboard_report_decoder_unit_assert.svh"
module hid_keyboard_report_decoder_unit
  import hkrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // report_length[6:0], report_byte_0..report_byte_8 at [14:7] .. [78:71], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // event_kind[3:0], character[10:4], caps_lock_on[11], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic       push, pop;
  job_t       wr_job, rd_job;
  fifo_stat_t fifo_stat;

  hkrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .job       (wr_job)
  );

  hkrd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (fifo_stat)
  );

  hkrd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (rd_job),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `HKRD_ASSERT_NOW(a_pop_not_empty, pop, !fifo_stat.empty)
  `HKRD_ASSERT_NEXT(a_pop_gives_last, pop, out_tvalid && out_tlast)
  `HKRD_ASSERT_NOW(a_char_consistent, out_tvalid, (out_tdata[3:0] == EV_CHAR) == (out_tdata[10:4] != 7'd0))
  `HKRD_ASSERT_NOW(a_no_push_full, fifo_stat.full, !push)

endmodule

### design/hkrd_front.sv
// Report intake: prefix strip, key-set compare and job classification
module hkrd_front
  import hkrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  fifo_stat_t           fifo_stat,
  output logic                 push,
  output job_t                 job
);

  logic [KEY_SLOTS-1:0][7:0] prev_keys_r, prev_keys_nxt;
  logic [LEN_W-1:0]          len, elen;
  logic [REPORT_BYTES-1:0][7:0] b;
  logic                      pref, accept, long_enough, any, differ;
  logic [7:0]                mods;

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    len = in_tdata[LEN_W-1:0];
    for (int i = 0; i < REPORT_BYTES; i++) begin
      b[i] = in_tdata[LEN_W + 8*i +: 8];
    end
    pref = (len >= LEN_W'(4)) && (b[0] >= 8'd1) && (b[0] <= 8'd4) && (b[2] == 8'd0);
    elen = pref ? (len - LEN_W'(1)) : len;
    mods = pref ? b[1] : b[0];
    long_enough = (len >= LEN_W'(3));
    any = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if ((LEN_W'(2 + k) < elen) && (2 + k < 8)) begin
        job.keys[k] = pref ? b[3 + k] : b[2 + k];
      end else begin
        job.keys[k] = 8'h00;
      end
      job.emit[k] = code_emits(job.keys[k]);
      any = any | (job.keys[k] != 8'h00);
    end
    job.ctrl  = (mods & MOD_CTRL_MASK) != 8'h00;
    job.shift = (mods & MOD_SHIFT_MASK) != 8'h00;
    differ    = (job.keys != prev_keys_r);
    push      = accept && long_enough && any && differ && (job.emit != '0);
  end

  always_comb begin
    prev_keys_nxt = prev_keys_r;
    if (accept && long_enough) begin
      if (!any) begin
        prev_keys_nxt = '0;
      end else begin
        prev_keys_nxt = job.keys;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '0;
    end else begin
      prev_keys_r <= prev_keys_nxt;
    end
  end

endmodule

### design/hkrd_fifo.sv
// Two-entry job queue between intake and event generation
module hkrd_fifo
  import hkrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       wr_job,
  input  logic       pop,
  output job_t       rd_job,
  output fifo_stat_t stat
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign stat.empty = (count_r == 2'd0);
  assign stat.full  = (count_r == 2'd2);
  assign rd_job     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/hkrd_back.sv
// Event generator: walks emitting key slots and drives the result register
module hkrd_back
  import hkrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  job_t                  job,
  input  fifo_stat_t            fifo_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // event_kind[3:0], character[10:4], caps_lock_on[11]
  output logic                  out_tlast
);

  logic [KEY_SLOTS-1:0]  done_r;
  logic                  caps_r, out_valid_r, out_last_r, out_caps_r;
  event_kind_t           out_kind_r;
  logic [6:0]            out_ch_r;
  logic [KEY_SLOTS-1:0]  work, sel;
  logic [SLOT_IDX_W-1:0] idx;
  logic                  found, last, load, go, caps_nxt;
  logic [7:0]            code;
  key_event_t            ev;

  always_comb begin
    work  = job.emit & ~done_r;
    sel   = '0;
    idx   = '0;
    found = 1'b0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (work[k] && !found) begin
        sel[k] = 1'b1;
        idx    = SLOT_IDX_W'(k);
        found  = 1'b1;
      end
    end
    code     = job.keys[idx];
    ev       = decode_key(code, job.ctrl, job.shift, caps_r);
    caps_nxt = caps_r ^ (code == KEY_CAPS);
    last     = (work & ~sel) == '0;
    load     = !out_valid_r || out_tready;
    go       = !fifo_stat.empty && load;
    pop      = go && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      caps_r      <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= go;
      end
      if (go) begin
        caps_r <= caps_nxt;
        done_r <= last ? '0 : (done_r | sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_kind_r <= ev.kind;
      out_ch_r   <= ev.ch;
      out_caps_r <= caps_nxt;
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_caps_r, out_ch_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

### tb/hid_keyboard_report_decoder_unit_test.sv
// Testbench for the HID boot keyboard report decoder: directed and random reports, self-checking
`timescale 1ns / 100ps
module hid_keyboard_report_decoder_unit_test;
  import hkrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 88;

  typedef struct {
    event_kind_t kind;
    logic [6:0]  ch;
    logic        caps;
    logic        last;
  } key_event_exp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  logic [IN_DATA_W-1:0] report_queue[$];
  key_event_exp_t       pending_key_events[$];
  key_event_exp_t       got_event;
  logic [IN_DATA_W-1:0] last_formed = '0;
  logic [7:0]           held_keys[KEY_SLOTS];
  logic                 caps_state = 1'b0;
  logic                 in_took = 1'b0;
  logic                 hold_req = 1'b0;
  logic                 hold_used = 1'b0;
  int                   hold_left = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   errors = 0;
  int                   cycle_count = 0;

  hid_keyboard_report_decoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [6:0] ascii_of(input logic [7:0] code, input logic shift,
                                          input logic caps);
    string digits_lo;
    string digits_hi;
    string syms_lo;
    string syms_hi;
    logic [6:0] c;
    digits_lo = "1234567890";
    digits_hi = "!@#$%^&*()";
    syms_lo   = " -=[]\\ ;'`,./";
    syms_hi   = " _+{}| :\"~<>?";
    c = 7'h00;
    if (code >= KEY_A && code <= KEY_Z) begin
      c = 7'h61 + 7'(code - KEY_A);
      if (shift ^ caps) c = c - 7'd32;
    end else if (code >= KEY_1 && code <= KEY_0) begin
      c = shift ? 7'(digits_hi[code - KEY_1]) : 7'(digits_lo[code - KEY_1]);
    end else if (code >= KEY_SPACE && code <= KEY_SLASH && code != KEY_NON_US) begin
      c = shift ? 7'(syms_hi[code - KEY_SPACE]) : 7'(syms_lo[code - KEY_SPACE]);
    end
    return c;
  endfunction

  // Decode one accepted report, update key memory and caps state, queue its events
  task automatic predict_key_events(input logic [IN_DATA_W-1:0] d);
    logic [7:0]     b[REPORT_BYTES];
    logic [7:0]     keys[KEY_SLOTS];
    logic [7:0]     m;
    logic [7:0]     code;
    logic           ctrl;
    logic           shift;
    logic           has_key;
    logic           same;
    logic           emits;
    int             len;
    int             off;
    key_event_exp_t e;
    key_event_exp_t evs[$];
    len = int'(d[6:0]);
    for (int k = 0; k < REPORT_BYTES; k++) b[k] = d[7 + 8*k +: 8];
    if (len < 3) return;
    off = 0;
    if (len >= 4 && b[0] >= 8'd1 && b[0] <= 8'd4 && b[2] == 8'd0) begin
      off = 1;
      len = len - 1;
    end
    m = b[off];
    ctrl = |(m & MOD_CTRL_MASK);
    shift = |(m & MOD_SHIFT_MASK);
    has_key = 1'b0;
    same = 1'b1;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      keys[k] = (k + 2 < len && k + 2 < 8) ? b[off + 2 + k] : 8'h00;
      if (keys[k] != 8'h00) has_key = 1'b1;
      if (keys[k] != held_keys[k]) same = 1'b0;
    end
    if (!has_key) begin
      foreach (held_keys[k]) held_keys[k] = 8'h00;
      return;
    end
    if (same) return;
    foreach (held_keys[k]) held_keys[k] = keys[k];
    for (int k = 0; k < KEY_SLOTS; k++) begin
      code = keys[k];
      emits = (code != 8'h00);
      e.ch = 7'h00;
      e.kind = EV_CHAR;
      if (code == KEY_CAPS) begin
        caps_state = ~caps_state;
        e.kind = EV_LEDS;
      end else if (code == KEY_ESCAPE) e.kind = EV_ESCAPE;
      else if (ctrl && code == KEY_L) e.kind = EV_URL_FOCUS;
      else if (code == KEY_UP) e.kind = EV_SCROLL_UP;
      else if (code == KEY_DOWN) e.kind = EV_SCROLL_DOWN;
      else if (code == KEY_LEFT) e.kind = EV_LEFT;
      else if (code == KEY_RIGHT) e.kind = EV_RIGHT;
      else if (code == KEY_ENTER) e.kind = EV_ENTER;
      else if (code == KEY_BACKSPACE) e.kind = EV_BACKSPACE;
      else begin
        e.ch = ascii_of(code, shift, caps_state);
        if (e.ch == 7'h00) emits = 1'b0;
      end
      if (emits) begin
        e.caps = caps_state;
        e.last = 1'b0;
        evs.push_back(e);
      end
    end
    for (int k = 0; k < evs.size(); k++) begin
      e = evs[k];
      e.last = (k == evs.size() - 1);
      pending_key_events.push_back(e);
    end
  endtask

  // Plain report: modifier, reserved zero, six key slots (slot 0 in the top byte)
  function automatic logic [IN_DATA_W-1:0] kb(input logic [6:0] len, input logic [7:0] mod,
                                               input logic [47:0] keys);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[6:0] = len;
    d[14:7] = mod;
    for (int k = 0; k < KEY_SLOTS; k++) d[7 + 8*(2+k) +: 8] = keys[47 - 8*k -: 8];
    return d;
  endfunction

  // Report with a leading report ID byte
  function automatic logic [IN_DATA_W-1:0] kb_id(input logic [6:0] len, input logic [7:0] id,
                                                  input logic [7:0] mod, input logic [47:0] keys);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[6:0] = len;
    d[14:7] = id;
    d[22:15] = mod;
    for (int k = 0; k < KEY_SLOTS; k++) d[7 + 8*(3+k) +: 8] = keys[47 - 8*k -: 8];
    return d;
  endfunction

  function automatic logic [7:0] rand_key();
    logic [7:0] nav[8];
    int r;
    nav = '{KEY_ESCAPE, KEY_L, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_ENTER, KEY_BACKSPACE};
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(KEY_A, KEY_Z));
    if (r < 60) return 8'($urandom_range(KEY_1, KEY_0));
    if (r < 75) return 8'($urandom_range(KEY_SPACE, KEY_SLASH));
    if (r < 85) return nav[$urandom_range(7)];
    if (r < 90) return KEY_CAPS;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_report();
    logic [IN_DATA_W-1:0] d;
    logic [47:0]          keys;
    logic [7:0]           mod;
    int                   r;
    r = $urandom_range(99);
    if (r < 10) return last_formed;
    if (r < 15) return kb(7'd8, 8'($urandom_range(255)), 48'h0);
    if (r < 27) begin
      d = IN_DATA_W'({$urandom, $urandom, $urandom});
      d[6:0] = 7'($urandom_range(64));
      d[IN_DATA_W-1] = 1'b0;
      return d;
    end
    for (int k = 0; k < KEY_SLOTS; k++)
      keys[8*k +: 8] = ($urandom_range(3) == 0) ? 8'h00 : rand_key();
    mod = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : 8'h00;
    if ($urandom_range(6) == 0) begin
      d = kb_id(7'd9, 8'($urandom_range(1, 4)), mod, keys);
    end else begin
      d = kb(($urandom_range(99) < 85) ? 7'd8 : 7'($urandom_range(3, 64)), mod, keys);
      if ($urandom_range(4) == 0) d[22:15] = 8'($urandom_range(255));
      d[78:71] = 8'($urandom_range(255));
    end
    last_formed = d;
    return d;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (report_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata <= report_queue.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the intake queue fills and back-pressures
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_key_events.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none, got kind %0d char %02h caps %0b last %0b",
                   $time, out_tdata[3:0], out_tdata[10:4], out_tdata[11], out_tlast);
        end else begin
          got_event = pending_key_events.pop_front();
          if (out_tdata[3:0] !== got_event.kind || out_tdata[10:4] !== got_event.ch ||
              out_tdata[11] !== got_event.caps || out_tlast !== got_event.last) begin
            errors++;
            $display("%0t mismatch: expected kind %0d char %02h caps %0b last %0b,",
                     $time, got_event.kind, got_event.ch, got_event.caps, got_event.last);
            $display("  got kind %0d char %02h caps %0b last %0b",
                     out_tdata[3:0], out_tdata[10:4], out_tdata[11], out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) predict_key_events(in_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int sender_idle[4];
    int receiver_stall[4];
    sender_idle = '{0, 47, 0, 38};
    receiver_stall = '{0, 0, 47, 38};
    foreach (held_keys[k]) held_keys[k] = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    report_queue.push_back(kb(7'd0, 8'h00, 48'h040506070809));
    report_queue.push_back(kb(7'd2, 8'h00, 48'h040506070809));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h040506070809));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h040506070809));
    report_queue.push_back(kb(7'd8, 8'h02, 48'h040506070809));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h000000000000));
    report_queue.push_back(kb(7'd8, 8'h20, 48'h040506070809));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h39041D000000));
    report_queue.push_back(kb(7'd8, 8'h02, 48'h04391D000000));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h295251504F28));
    report_queue.push_back(kb(7'd8, 8'h01, 48'h2A0F00000000));
    report_queue.push_back(kb(7'd8, 8'h10, 48'h0F0000000000));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h0F0000000000));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h1E1F20212223));
    report_queue.push_back(kb(7'd8, 8'h02, 48'h242526271E23));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h2C2D2E2F3031));
    report_queue.push_back(kb(7'd8, 8'h22, 48'h323334353637));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h383233343536));
    report_queue.push_back(kb(7'd8, 8'h00, 48'h0102033AFF32));
    report_queue.push_back(kb_id(7'd9, 8'h02, 8'h02, 48'h040500000000));
    report_queue.push_back(kb_id(7'd4, 8'h03, 8'h00, 48'h060708090A0B));
    report_queue.push_back(kb(7'd5, 8'h00, 48'h0708090A0B0C));
    report_queue.push_back({1'b0, {REPORT_BYTES{8'hFF}}, 7'd64});
    report_queue.push_back({1'b0, {REPORT_BYTES{8'h00}}, 7'd64});
    report_queue.push_back(kb(7'd8, 8'hFF, 48'h0F041E2D3939));
    while (report_queue.size() != 0 || in_tvalid || pending_key_events.size() != 0)
      @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sender_idle[p];
      stall_pct = receiver_stall[p];
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) report_queue.push_back(random_report());
      while (report_queue.size() != 0 || in_tvalid || pending_key_events.size() != 0)
        @(posedge clk);
    end

    repeat (20) @(posedge clk);
    if (pending_key_events.size() != 0) errors++;
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/hkrd_pkg.sv
design/hkrd_front.sv
design/hkrd_fifo.sv
design/hkrd_back.sv
design/hid_keyboard_report_decoder_unit.sv
tb/hid_keyboard_report_decoder_unit_test.sv
